@@ hw/rtl/sec_pkg.sv @@
// Shared constants, access codes and types for the serial EEPROM command port.
package sec_pkg;

   // Access kinds carried in tuser
   localparam logic [1:0] OP_START  = 2'd0;
   localparam logic [1:0] OP_SERIAL = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam int WORD_COUNT_DEFAULT = 64;
   localparam int WORD_W             = 16;
   localparam int BYTE_W             = 8;
   localparam int OTHER_W            = 7;
   localparam int POS_W              = 5;
   localparam int ADDR_SHIFT_W       = 6;

   // Frame layout: four header bytes, six address bits, sixteen data bits
   localparam int HEADER_BYTES = 4;
   localparam int READ_POINT   = 10;
   localparam int FRAME_BITS   = 26;

   // Header bytes in order of arrival, first byte in the top bits
   localparam logic [31:0] HDR_READ  = 32'h00FF_FF00;
   localparam logic [31:0] HDR_WRITE = 32'h00FF_00FF;

   localparam logic [WORD_W-1:0] WORD_ERASED = 16'hFFFF;

   // Requests from the frame collector to the word store
   typedef struct packed {
      logic load;
      logic store;
   } frame_ctrl_type;

endpackage

@@ hw/rtl/serial_eeprom_command_port.sv @@
// Top level of the serial EEPROM command port: word store, read shift and result register.
//
// Serial EEPROM of WORD_COUNT words of 16 bits behind byte-wide port accesses.
// Each input word is one port access, its kind in req_tuser: a start line
// write, a serial bit write or a data port read. The port takes one word per
// clock cycle unless a held result stalls it; only a read returns a word, in
// the cycle after it is taken, from the result register. While a result waits
// unclaimed on rsp_*, req_tready drops, stalling the input while it is held.
// Serial writes fill a 26-bit frame: four header bytes, six address bits,
// sixteen data bits, any nonzero byte counting as a one. A frame with header
// 00,FF,FF,00 loads the addressed word into the read shift register once the
// tenth position is filled; one with header 00,FF,00,FF writes the data word
// at the twenty-sixth. A falling edge of the start line restarts the frame.
// The store sits in a RAM with a registered read; a valid bit per word makes
// unwritten words read as all ones, so there is no clearing pass after reset.
module serial_eeprom_command_port #(
   parameter int WORD_COUNT = sec_pkg::WORD_COUNT_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // Input channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // [7:0] bus_data, [14:8] port_other_bits, [15] zero
   input  logic [1:0]  req_tuser,  // [1:0] opcode
   // Result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata   // [7:0] read_byte
);
   import sec_pkg::*;

   localparam int ADDR_W = $clog2(WORD_COUNT);

   logic                    req_accept;
   logic [1:0]              opcode;
   logic [BYTE_W-1:0]       bus_data;
   logic [OTHER_W-1:0]      other_bits;
   frame_ctrl_type          ctrl;
   logic [ADDR_SHIFT_W-1:0] frame_addr;
   logic [WORD_W-1:0]       frame_data;
   logic [ADDR_W-1:0]       word_addr;
   logic [WORD_W-1:0]       ram_rd_data;

   logic [WORD_COUNT-1:0]   valid_ff, valid_in;
   logic                    fill_valid_ff;
   logic                    load_pending_ff;
   logic [WORD_W-1:0]       read_shift_ff, read_shift_in;
   logic [WORD_W-1:0]       read_shift_cur;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]       rsp_data_ff, rsp_data_in;
   logic                    read_take;

   // Unpack the access
   assign opcode     = req_tuser;
   assign bus_data   = req_tdata[7:0];
   assign other_bits = req_tdata[14:8];

   // Take a new word whenever the result register is empty or draining
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign read_take  = req_accept && (opcode == OP_READ);

   sec_serial u_serial (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_accept),
      .opcode     (opcode),
      .bus_data   (bus_data),
      .ctrl       (ctrl),
      .frame_addr (frame_addr),
      .frame_data (frame_data)
   );

   assign word_addr = frame_addr[ADDR_W-1:0];

   sec_ram #(
      .WIDTH (WORD_W),
      .DEPTH (WORD_COUNT)
   ) u_store (
      .clock   (clock),
      .wr_en   (ctrl.store),
      .wr_addr (word_addr),
      .wr_data (frame_data),
      .rd_en   (ctrl.load),
      .rd_addr (word_addr),
      .rd_data (ram_rd_data)
   );

   // Mark a word valid once it has been written
   always_comb begin
      valid_in = valid_ff;
      if (ctrl.store) begin
         valid_in[word_addr] = 1'b1;
      end
   end

   // A load lands in the cycle after it is issued; use the RAM output directly in that cycle
   always_comb begin
      if (load_pending_ff) begin
         read_shift_cur = fill_valid_ff ? ram_rd_data : WORD_ERASED;
      end else begin
         read_shift_cur = read_shift_ff;
      end
   end

   // Shift left with a one fill on every read, and build the result
   always_comb begin
      read_shift_in = read_shift_cur;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      if (read_take) begin
         read_shift_in = {read_shift_cur[WORD_W-2:0], 1'b1};
         rsp_data_in   = {read_shift_cur[WORD_W-1], other_bits};
         rsp_valid_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff        <= '0;
         load_pending_ff <= 1'b0;
         read_shift_ff   <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         valid_ff        <= valid_in;
         load_pending_ff <= ctrl.load;
         read_shift_ff   <= read_shift_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (ctrl.load) begin
         fill_valid_ff <= valid_ff[word_addr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ hw/rtl/sec_ram.sv @@
// Generic single-port-write, registered-read RAM.
module sec_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/sec_serial.sv @@
// Serial frame collector: bit position, start edge, header, address and data shifts.
module sec_serial (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic [1:0]                     opcode,
   input  logic [sec_pkg::BYTE_W-1:0]     bus_data,
   output sec_pkg::frame_ctrl_type        ctrl,
   output logic [sec_pkg::ADDR_SHIFT_W-1:0] frame_addr,
   output logic [sec_pkg::WORD_W-1:0]     frame_data
);
   import sec_pkg::*;

   logic [POS_W-1:0]        pos_ff, pos_in;
   logic                    start_high_ff, start_high_in;
   logic [BYTE_W-1:0]       header_ff [HEADER_BYTES];
   logic [ADDR_SHIFT_W-1:0] addr_ff, addr_in;
   logic [WORD_W-1:0]       data_ff, data_in;
   logic                    one;
   logic                    serial_take;
   logic                    header_wr;
   logic [31:0]             header_word;

   assign one         = |bus_data;
   assign header_word = {header_ff[0], header_ff[1], header_ff[2], header_ff[3]};
   assign serial_take = accept && (opcode == OP_SERIAL) && (pos_ff < POS_W'(FRAME_BITS));

   always_comb begin
      pos_in        = pos_ff;
      start_high_in = start_high_ff;
      addr_in       = addr_ff;
      data_in       = data_ff;
      header_wr     = 1'b0;
      if (accept && (opcode == OP_START)) begin
         if (!one && start_high_ff) begin
            pos_in = '0;
         end
         start_high_in = one;
      end else if (serial_take) begin
         if (pos_ff < POS_W'(HEADER_BYTES)) begin
            header_wr = 1'b1;
         end else if (pos_ff < POS_W'(READ_POINT)) begin
            addr_in = {addr_ff[ADDR_SHIFT_W-2:0], one};
         end else begin
            data_in = {data_ff[WORD_W-2:0], one};
         end
         pos_in = pos_ff + POS_W'(1);
      end
   end

   always_comb begin
      ctrl.load  = serial_take && (pos_ff == POS_W'(READ_POINT - 1)) &&
                   (header_word == HDR_READ);
      ctrl.store = serial_take && (pos_ff == POS_W'(FRAME_BITS - 1)) &&
                   (header_word == HDR_WRITE);
   end

   assign frame_addr = addr_in;
   assign frame_data = data_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         start_high_ff <= 1'b0;
      end else begin
         pos_ff        <= pos_in;
         start_high_ff <= start_high_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      data_ff <= data_in;
      if (header_wr) begin
         header_ff[pos_ff[1:0]] <= bus_data;
      end
   end

endmodule

@@ hw/rtl/sec_checker.sv @@
// Port-level checker for the serial EEPROM command port, bound to the top level.
module sec_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [15:0] req_tdata,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata
);
   import sec_pkg::*;

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed or dropped");

   // A taken read shows up next cycle carrying the other port bits
   a_read_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == OP_READ)
      |=> rsp_tvalid && (rsp_tdata[6:0] == $past(req_tdata[14:8])))
      else $error("read did not produce its result");

   // Accesses other than reads produce nothing
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid && !(req_tvalid && req_tready && (req_tuser == OP_READ))
      |=> !rsp_tvalid)
      else $error("result without a read");

   // The read shift register is clear right after reset
   a_reset_read: assert property (@(posedge clock) disable iff (reset)
      $past(reset) && req_tvalid && req_tready && (req_tuser == OP_READ)
      |=> rsp_tdata[7] == 1'b0)
      else $error("first read after reset not zero");

endmodule

bind serial_eeprom_command_port sec_checker u_sec_checker (.*);
